FILE: rtl/prst_pkg.sv
// Shared types, codes and constants for the probe request SSID tracker.
// No dependencies.
package prst_pkg;

  localparam int TableDepthDefault = 64;
  localparam int SSID_MAX          = 32;
  localparam int SSID_W            = 5;     // log2 of SSID_MAX

  // Input command codes
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_SORT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_MISS    = 2'd2;
  localparam logic [1:0] KIND_SORTED  = 2'd3;

  // Frame verdicts
  localparam logic [1:0] VRD_REJECT = 2'd0;
  localparam logic [1:0] VRD_MATCH  = 2'd1;
  localparam logic [1:0] VRD_ADDED  = 2'd2;
  localparam logic [1:0] VRD_FULL   = 2'd3;

  // Frame format
  localparam logic [7:0]  FC_PROBE    = 8'h40;
  localparam logic [7:0]  TAG_SSID    = 8'h00;
  localparam logic [11:0] MIN_LEN     = 12'd28;
  localparam logic [11:0] POS_TAG     = 12'd24;
  localparam logic [11:0] POS_TAGLEN  = 12'd25;
  localparam logic [11:0] SSID_OFS    = 12'd26;
  localparam logic [11:0] POS_MAX     = 12'd4095;
  localparam logic [7:0]  PRINT_LOW   = 8'd32;
  localparam logic [7:0]  PRINT_HIGH  = 8'd126;
  localparam logic [7:0]  SSID_LEN_MX = 8'd32;

  typedef struct packed {
    logic [5:0]  len;
    logic [31:0] hits;
    logic [7:0]  strength;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic       take_byte;
    logic       restart;
    logic       bump_total;
    logic       i_clr;
    logic       i_inc;
    logic       i_load_idx;
    logic       k_clr;
    logic       k_inc;
    logic       p_set1;
    logic       p_inc;
    logic       rd_ent;
    logic       rd_byte;
    logic       rd_latch;
    logic       wr_hit;
    logic       wr_new;
    logic       inc_count;
    logic       wr_cap;
    logic       sw_ent_a;
    logic       sw_ent_b;
    logic       sw_byte_a;
    logic       sw_byte_b;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] out_verdict;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       frame_end;
    logic       frame_valid;
    logic       ent_done;
    logic       table_full;
    logic       idx_miss;
    logic       len_match;
    logic       byte_match;
    logic       k_ge_tag;
    logic       k_rd_last;
    logic       k_end;
    logic       p_ge_n;
    logic       jp_lt_n;
    logic       hits_lt;
    logic       out_free;
  } dp_status_t;

endpackage

FILE: rtl/probe_request_ssid_tracker.sv
// Top level of the probe request SSID tracker: controller plus datapath.
// Depends on prst_pkg, prst_ctrl, prst_datapath.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  command .. entry_index
//   out       source     out_valid/out_stall  result_kind .. last_of_run
//
// A frame byte without frame end is accepted (S_IDLE) and parsed (S_DECODE).
// Frame end adds the table search: each entry's SSID length is compared,
// then each SSID byte of an entry of equal length; a new entry has its
// SSID bytes copied one by one. Read: the entry is fetched, then each SSID
// byte is read and sent as its own result. Sort: bubble sort over the entry
// memory; a swap rewrites the entry fields and 32 SSID bytes, one port write
// per cycle.
// Reset (rst, synchronous) clears the parser, counts and control; the
// tables need no clearing since only written entries are ever read.
// A stalled output holds the next result; input stays stalled until the
// current item is finished.
module probe_request_ssid_tracker
  import prst_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  input  logic              is_management,
  input  logic signed [7:0] signal_strength,
  input  logic [31:0]       now_ms,
  input  logic [5:0]        entry_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        result_kind,
  output logic [1:0]        frame_verdict,
  output logic [5:0]        slot_index,
  output logic [6:0]        unique_count,
  output logic [31:0]       total_valid,
  output logic [7:0]        ssid_byte,
  output logic [31:0]       hit_count,
  output logic signed [7:0] entry_strength,
  output logic [31:0]       last_seen_ms,
  output logic              last_of_run
);

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic       in_accept;

  // sequencing of every multi-cycle operation
  prst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, parser and the result register
  prst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_accept       (in_accept),
    .command         (command),
    .data_byte       (data_byte),
    .frame_end       (frame_end),
    .is_management   (is_management),
    .signal_strength (signal_strength),
    .now_ms          (now_ms),
    .entry_index     (entry_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .frame_verdict   (frame_verdict),
    .slot_index      (slot_index),
    .unique_count    (unique_count),
    .total_valid     (total_valid),
    .ssid_byte       (ssid_byte),
    .hit_count       (hit_count),
    .entry_strength  (entry_strength),
    .last_seen_ms    (last_seen_ms),
    .last_of_run     (last_of_run)
  );

endmodule

FILE: rtl/prst_datapath.sv
// Datapath: frame parser, entry and SSID memories, counters, result register.
// Depends on prst_pkg; driven by prst_ctrl.
module prst_datapath
  import prst_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_accept,
  input  logic [1:0]         command,
  input  logic [7:0]         data_byte,
  input  logic               frame_end,
  input  logic               is_management,
  input  logic signed [7:0]  signal_strength,
  input  logic [31:0]        now_ms,
  input  logic [5:0]         entry_index,
  input  dp_cmd_t            cmd,
  output dp_status_t         sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [1:0]         frame_verdict,
  output logic [5:0]         slot_index,
  output logic [6:0]         unique_count,
  output logic [31:0]        total_valid,
  output logic [7:0]         ssid_byte,
  output logic [31:0]        hit_count,
  output logic signed [7:0]  entry_strength,
  output logic [31:0]        last_seen_ms,
  output logic               last_of_run
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = IW + SSID_W;
  localparam int SDEPTH = TABLE_DEPTH * SSID_MAX;

  // latched item
  logic [1:0]  cmd_l;
  logic [7:0]  data_l;
  logic        end_l;
  logic        mgmt_l;
  logic [7:0]  str_l;
  logic [31:0] now_l;
  logic [5:0]  idx_l;

  // parser
  logic [11:0] byte_position, byte_position_next;
  logic        frame_ok, frame_ok_next;
  logic [7:0]  tag_length, tag_length_next;
  logic [7:0]  capture_buffer [SSID_MAX];
  logic        cap_we;
  logic [11:0] cap_ofs;

  logic [CW-1:0] entry_count;
  logic [31:0]   total_captured;
  logic [CW-1:0] i;
  logic [CW-1:0] p;
  logic [5:0]    k;
  logic [IW-1:0] ip1;

  entry_t entry_mem [TABLE_DEPTH];
  logic [7:0] ssid_store [SDEPTH];
  entry_t ent_a, ent_b;
  logic [7:0] byte_a, byte_b;

  logic [5:0]  res_slot;
  logic [31:0] res_hits;
  logic [7:0]  res_str;
  logic [31:0] res_seen;
  logic [5:0]  rlen;

  logic          ewe;
  logic [IW-1:0] ewa;
  entry_t        ewd;
  logic          swe;
  logic [AW-1:0] swa;
  logic [7:0]    swd;
  logic [31:0]   hits_inc;
  logic [5:0]    len_rd;

  assign ip1 = i[IW-1:0] + IW'(1);
  assign hits_inc = (ent_a.hits == 32'hFFFF_FFFF) ? ent_a.hits : ent_a.hits + 32'd1;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_l  <= command;
      data_l <= data_byte;
      end_l  <= frame_end;
      mgmt_l <= is_management;
      str_l  <= signal_strength;
      now_l  <= now_ms;
      idx_l  <= entry_index;
    end
  end

  // byte checks
  always_comb begin
    frame_ok_next      = frame_ok;
    tag_length_next    = tag_length;
    cap_we             = 1'b0;
    cap_ofs            = byte_position - SSID_OFS;
    byte_position_next = (byte_position < POS_MAX) ? byte_position + 12'd1 : byte_position;
    if (byte_position == 12'd0 && data_l != FC_PROBE) begin
      frame_ok_next = 1'b0;
    end else if (byte_position == POS_TAG && data_l != TAG_SSID) begin
      frame_ok_next = 1'b0;
    end else if (byte_position == POS_TAGLEN) begin
      tag_length_next = data_l;
      if (data_l == 8'd0 || data_l > SSID_LEN_MX) frame_ok_next = 1'b0;
    end else if (byte_position >= SSID_OFS &&
                 byte_position < SSID_OFS + {4'd0, tag_length} &&
                 cap_ofs < 12'(SSID_MAX)) begin
      if (data_l < PRINT_LOW || data_l > PRINT_HIGH) frame_ok_next = 1'b0;
      cap_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_ok      <= 1'b1;
      tag_length    <= '0;
    end else if (cmd.restart) begin
      byte_position <= '0;
      frame_ok      <= 1'b1;
      tag_length    <= '0;
    end else if (cmd.take_byte) begin
      byte_position <= byte_position_next;
      frame_ok      <= frame_ok_next;
      tag_length    <= tag_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && cap_we) capture_buffer[cap_ofs[SSID_W-1:0]] <= data_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      total_captured <= '0;
    end else begin
      if (cmd.inc_count) entry_count <= entry_count + CW'(1);
      if (cmd.bump_total) total_captured <= total_captured + 32'd1;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (cmd.i_clr) i <= '0;
    else if (cmd.i_inc) i <= i + CW'(1);
    else if (cmd.i_load_idx) i <= CW'(idx_l);
    if (cmd.k_clr) k <= '0;
    else if (cmd.k_inc) k <= k + 6'd1;
    if (cmd.p_set1) p <= CW'(1);
    else if (cmd.p_inc) p <= p + CW'(1);
  end

  // entry memory: one write port, two registered reads
  always_comb begin
    ewe = 1'b1;
    ewa = i[IW-1:0];
    ewd = ent_b;
    if (cmd.wr_hit) begin
      ewd = '{len: ent_a.len, hits: hits_inc, strength: str_l, seen: now_l};
    end else if (cmd.wr_new) begin
      ewa = entry_count[IW-1:0];
      ewd = '{len: tag_length[5:0], hits: 32'd1, strength: str_l, seen: now_l};
    end else if (cmd.sw_ent_a) begin
      ewd = ent_b;
    end else if (cmd.sw_ent_b) begin
      ewa = ip1;
      ewd = ent_a;
    end else begin
      ewe = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ewe) entry_mem[ewa] <= ewd;
    if (cmd.rd_ent) begin
      ent_a <= entry_mem[i[IW-1:0]];
      ent_b <= entry_mem[ip1];
    end
  end

  // SSID byte memory
  always_comb begin
    swe = 1'b1;
    swa = {i[IW-1:0], k[SSID_W-1:0]};
    swd = byte_b;
    if (cmd.wr_cap) begin
      swa = {entry_count[IW-1:0], k[SSID_W-1:0]};
      swd = capture_buffer[k[SSID_W-1:0]];
    end else if (cmd.sw_byte_a) begin
      swd = byte_b;
    end else if (cmd.sw_byte_b) begin
      swa = {ip1, k[SSID_W-1:0]};
      swd = byte_a;
    end else begin
      swe = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (swe) ssid_store[swa] <= swd;
    if (cmd.rd_byte) begin
      byte_a <= ssid_store[{i[IW-1:0], k[SSID_W-1:0]}];
      byte_b <= ssid_store[{ip1, k[SSID_W-1:0]}];
    end
  end

  // result staging
  assign len_rd = (ent_a.len > 6'd32) ? 6'd32 : ((ent_a.len == 6'd0) ? 6'd1 : ent_a.len);

  always_ff @(posedge clk) begin
    if (cmd.wr_hit) begin
      res_slot <= 6'(i);
      res_hits <= hits_inc;
      res_str  <= str_l;
      res_seen <= now_l;
    end else if (cmd.wr_new) begin
      res_slot <= 6'(entry_count);
      res_hits <= 32'd1;
      res_str  <= str_l;
      res_seen <= now_l;
    end else if (cmd.rd_latch) begin
      res_hits <= ent_a.hits;
      res_str  <= ent_a.strength;
      res_seen <= ent_a.seen;
      rlen     <= len_rd;
    end
  end

  // output register
  logic show_entry;
  assign show_entry = (cmd.out_kind == KIND_BYTE) ||
                      (cmd.out_kind == KIND_VERDICT &&
                       (cmd.out_verdict == VRD_MATCH || cmd.out_verdict == VRD_ADDED));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_kind    <= cmd.out_kind;
      frame_verdict  <= cmd.out_verdict;
      unique_count   <= 7'(entry_count);
      total_valid    <= total_captured;
      last_of_run    <= cmd.out_last;
      ssid_byte      <= (cmd.out_kind == KIND_BYTE) ? byte_a : 8'd0;
      hit_count      <= show_entry ? res_hits : 32'd0;
      entry_strength <= show_entry ? res_str : 8'd0;
      last_seen_ms   <= show_entry ? res_seen : 32'd0;
      if (cmd.out_kind == KIND_BYTE || cmd.out_kind == KIND_MISS) slot_index <= idx_l;
      else if (show_entry) slot_index <= res_slot;
      else slot_index <= 6'd0;
    end
  end

  // status
  always_comb begin
    sts.cmd         = cmd_l;
    sts.frame_end   = end_l;
    sts.frame_valid = frame_ok && mgmt_l && byte_position >= MIN_LEN &&
                      tag_length >= 8'd1 && tag_length <= SSID_LEN_MX &&
                      SSID_OFS + {4'd0, tag_length} <= byte_position;
    sts.ent_done    = i >= entry_count;
    sts.table_full  = 32'(entry_count) >= 32'(TABLE_DEPTH);
    sts.idx_miss    = {26'd0, idx_l} >= 32'(entry_count);
    sts.len_match   = {2'd0, ent_a.len} == tag_length;
    sts.byte_match  = byte_a == capture_buffer[k[SSID_W-1:0]];
    sts.k_ge_tag    = {2'd0, k} >= tag_length;
    sts.k_rd_last   = (k + 6'd1) == rlen;
    sts.k_end       = k[SSID_W];
    sts.p_ge_n      = p >= entry_count;
    sts.jp_lt_n     = ({1'b0, i} + {1'b0, p}) < {1'b0, entry_count};
    sts.hits_lt     = ent_a.hits < ent_b.hits;
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

FILE: rtl/prst_ctrl.sv
// Controller state machine: sequences parsing, search, insert, read and sort.
// Depends on prst_pkg; drives prst_datapath.
module prst_ctrl
  import prst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       in_accept,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DECODE    = 5'd1;
  localparam logic [4:0] S_FIN       = 5'd2;
  localparam logic [4:0] S_SRCH_RD   = 5'd3;
  localparam logic [4:0] S_SRCH_LEN  = 5'd4;
  localparam logic [4:0] S_SRCH_BRD  = 5'd5;
  localparam logic [4:0] S_SRCH_BCMP = 5'd6;
  localparam logic [4:0] S_ADD       = 5'd7;
  localparam logic [4:0] S_EMIT      = 5'd8;
  localparam logic [4:0] S_MISS      = 5'd9;
  localparam logic [4:0] S_RD_ENT    = 5'd10;
  localparam logic [4:0] S_RD_LEN    = 5'd11;
  localparam logic [4:0] S_RD_REQ    = 5'd12;
  localparam logic [4:0] S_RD_OUT    = 5'd13;
  localparam logic [4:0] S_SORT_CHK  = 5'd14;
  localparam logic [4:0] S_SORT_CMP  = 5'd15;
  localparam logic [4:0] S_SORT_SWB  = 5'd16;
  localparam logic [4:0] S_SWP_RD    = 5'd17;
  localparam logic [4:0] S_SWP_WA    = 5'd18;
  localparam logic [4:0] S_SWP_WB    = 5'd19;
  localparam logic [4:0] S_SORT_DONE = 5'd20;

  logic [4:0] state, state_next;
  logic [1:0] verdict, verdict_next;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      verdict <= VRD_REJECT;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    verdict_next = verdict;
    case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_BYTE: begin
            cmd.take_byte = 1'b1;
            state_next = sts.frame_end ? S_FIN : S_IDLE;
          end
          CMD_READ: begin
            if (sts.idx_miss) begin
              state_next = S_MISS;
            end else begin
              cmd.i_load_idx = 1'b1;
              cmd.k_clr = 1'b1;
              state_next = S_RD_ENT;
            end
          end
          CMD_SORT: begin
            cmd.i_clr = 1'b1;
            cmd.p_set1 = 1'b1;
            state_next = S_SORT_CHK;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FIN: begin
        if (sts.frame_valid) begin
          cmd.bump_total = 1'b1;
          cmd.i_clr = 1'b1;
          state_next = S_SRCH_RD;
        end else begin
          verdict_next = VRD_REJECT;
          state_next = S_EMIT;
        end
      end
      S_SRCH_RD: begin
        if (sts.ent_done) begin
          cmd.k_clr = 1'b1;
          if (sts.table_full) begin
            verdict_next = VRD_FULL;
            state_next = S_EMIT;
          end else begin
            state_next = S_ADD;
          end
        end else begin
          cmd.rd_ent = 1'b1;
          state_next = S_SRCH_LEN;
        end
      end
      S_SRCH_LEN: begin
        if (sts.len_match) begin
          cmd.k_clr = 1'b1;
          state_next = S_SRCH_BRD;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_BRD: begin
        if (sts.k_ge_tag) begin
          cmd.wr_hit = 1'b1;
          verdict_next = VRD_MATCH;
          state_next = S_EMIT;
        end else begin
          cmd.rd_byte = 1'b1;
          state_next = S_SRCH_BCMP;
        end
      end
      S_SRCH_BCMP: begin
        if (sts.byte_match) begin
          cmd.k_inc = 1'b1;
          state_next = S_SRCH_BRD;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_ADD: begin
        if (sts.k_ge_tag) begin
          cmd.wr_new = 1'b1;
          cmd.inc_count = 1'b1;
          verdict_next = VRD_ADDED;
          state_next = S_EMIT;
        end else begin
          cmd.wr_cap = 1'b1;
          cmd.k_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_VERDICT;
          cmd.out_verdict = verdict;
          cmd.out_last = 1'b1;
          cmd.restart = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_MISS;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_ENT: begin
        cmd.rd_ent = 1'b1;
        state_next = S_RD_LEN;
      end
      S_RD_LEN: begin
        cmd.rd_latch = 1'b1;
        state_next = S_RD_REQ;
      end
      S_RD_REQ: begin
        if (sts.out_free) begin
          cmd.rd_byte = 1'b1;
          state_next = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = KIND_BYTE;
        cmd.out_last = sts.k_rd_last;
        cmd.k_inc = 1'b1;
        state_next = sts.k_rd_last ? S_IDLE : S_RD_REQ;
      end
      S_SORT_CHK: begin
        if (sts.p_ge_n) begin
          state_next = S_SORT_DONE;
        end else if (sts.jp_lt_n) begin
          cmd.rd_ent = 1'b1;
          state_next = S_SORT_CMP;
        end else begin
          cmd.p_inc = 1'b1;
          cmd.i_clr = 1'b1;
        end
      end
      S_SORT_CMP: begin
        if (sts.hits_lt) begin
          cmd.sw_ent_a = 1'b1;
          state_next = S_SORT_SWB;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_SORT_CHK;
        end
      end
      S_SORT_SWB: begin
        cmd.sw_ent_b = 1'b1;
        cmd.k_clr = 1'b1;
        state_next = S_SWP_RD;
      end
      S_SWP_RD: begin
        if (sts.k_end) begin
          cmd.i_inc = 1'b1;
          state_next = S_SORT_CHK;
        end else begin
          cmd.rd_byte = 1'b1;
          state_next = S_SWP_WA;
        end
      end
      S_SWP_WA: begin
        cmd.sw_byte_a = 1'b1;
        state_next = S_SWP_WB;
      end
      S_SWP_WB: begin
        cmd.sw_byte_b = 1'b1;
        cmd.k_inc = 1'b1;
        state_next = S_SWP_RD;
      end
      S_SORT_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_SORTED;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/prst_checker.sv
// Port-level checks for the probe request SSID tracker, bound to the top.
// Depends on prst_pkg and probe_request_ssid_tracker.
module prst_checker
  import prst_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        result_kind,
  input logic [1:0]        frame_verdict,
  input logic [5:0]        slot_index,
  input logic [6:0]        unique_count,
  input logic [31:0]       hit_count,
  input logic [7:0]        ssid_byte
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ssid_byte) && $stable(slot_index))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_VERDICT && frame_verdict == VRD_REJECT
      |-> slot_index == 6'd0 && hit_count == 32'd0)
    else $error("rejected frame carries entry fields");

  a_added_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_VERDICT && frame_verdict == VRD_ADDED
      |-> unique_count == {1'b0, slot_index} + 7'd1 && hit_count == 32'd1)
    else $error("new entry not at end of table");

  a_read_in_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_BYTE |-> {1'b0, slot_index} < unique_count)
    else $error("read outside stored entries");

endmodule

bind probe_request_ssid_tracker prst_checker u_prst_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .result_kind   (result_kind),
  .frame_verdict (frame_verdict),
  .slot_index    (slot_index),
  .unique_count  (unique_count),
  .hit_count     (hit_count),
  .ssid_byte     (ssid_byte)
);
